[sv/vcfe_pkg.sv]
// shared types, constants and helper functions of the vertex cover fitness engine
package vcfe_pkg;

  // graph size and derived widths
  localparam int unsigned NumRows = 64;
  localparam int unsigned AddrW   = $clog2(NumRows);
  localparam int unsigned RowW    = 64;
  localparam int unsigned CountW  = 7;
  localparam int unsigned FitW    = 18;
  localparam int unsigned SumW    = 12;
  localparam int unsigned PopW    = 7;

  localparam logic [CountW-1:0] MaxVertices = CountW'(NumRows);
  localparam logic [CountW-1:0] CountReset  = CountW'(64);

  // command codes, the last one is a spare code answered with an all-zero result
  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdEval   = 2'd2,
    CmdUnused = 2'd3
  } cmd_e;

  // one input transaction
  typedef struct packed {
    logic [1:0]       command;
    logic [AddrW-1:0] first_vertex;
    logic [AddrW-1:0] second_vertex;
    logic [RowW-1:0]  member_mask;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic            accepted;
    logic [FitW-1:0] fitness;
    logic            cover_valid;
  } result_t;

  // access request to the adjacency row store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [RowW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // mask of the n lowest bits, n up to RowW
  function automatic logic [RowW-1:0] low_bits(input logic [CountW-1:0] n);
    logic [RowW-1:0] m;
    if (n >= CountW'(RowW)) begin
      m = '1;
    end else begin
      m = (RowW'(1) << n) - RowW'(1);
    end
    return m;
  endfunction

  // ones in one byte
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  // ones in a row, byte counts then their sum
  function automatic logic [PopW-1:0] pop_row(input logic [RowW-1:0] v);
    logic [PopW-1:0] c;
    c = '0;
    for (int k = 0; k < RowW / 8; k++) begin
      c = c + PopW'(pop8(v[k*8 +: 8]));
    end
    return c;
  endfunction

endpackage

[sv/vcfe_row_store.sv]
// adjacency row memory with per-row valid bits and registered read
module vcfe_row_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vcfe_pkg::mem_req_t                req_i,
  output logic [vcfe_pkg::RowW-1:0]         rdata_o
);

  logic [vcfe_pkg::RowW-1:0]    mem [vcfe_pkg::NumRows];
  logic [vcfe_pkg::RowW-1:0]    rdata_q;
  logic [vcfe_pkg::NumRows-1:0] row_valid_q;
  logic                         rvalid_q;

  // storage array, one write and one read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= row_valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q & {vcfe_pkg::RowW{rvalid_q}};

endmodule

[sv/vertex_cover_fitness_engine.sv]
// top level: command sequencer and fitness accumulation over the adjacency rows
//
//   channel   signals                        direction  transfer
//   command   start_i, busy_o, item_i        in         start_i high while busy_o low
//   result    done_o, result_o               out        done_o high for one cycle
//   config    cfg_we_i, cfg_wdata_i          in         cfg_we_i high, no wait
//
// add and remove do two row reads then two row writes on the row store.
// evaluate makes one row read per cycle for each of the n active vertices,
// n the active vertex count, then drains a two-stage count pipeline and
// ends with a multiply and a final add.
// an unused command code is answered in the cycle after acceptance.
// reset clears the whole matrix at once through per-row valid bits.
// the receiver cannot stall; busy_o stays high until the result is issued.
module vertex_cover_fitness_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  vcfe_pkg::item_t                item_i,
  output logic                           done_o,
  output vcfe_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [vcfe_pkg::CountW-1:0]    cfg_wdata_i
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StRdA     = 4'd1;
  localparam logic [3:0] StRdB     = 4'd2;
  localparam logic [3:0] StWrA     = 4'd3;
  localparam logic [3:0] StWrB     = 4'd4;
  localparam logic [3:0] StEvRead  = 4'd5;
  localparam logic [3:0] StEvDrain = 4'd6;
  localparam logic [3:0] StEvMul   = 4'd7;
  localparam logic [3:0] StEvFin   = 4'd8;

  logic [3:0]                    state_q, state_d;
  logic [vcfe_pkg::CountW-1:0]   vcount_q;
  logic [vcfe_pkg::CountW-1:0]   n_now;
  logic                          accept;

  logic [1:0]                    cmd_q;
  logic [vcfe_pkg::AddrW-1:0]    a_q, b_q;
  logic                          rng_q;
  logic [vcfe_pkg::CountW-1:0]   n_q;
  logic [vcfe_pkg::RowW-1:0]     inuse_q, unch_q;
  logic [vcfe_pkg::RowW-1:0]     rowa_q, rowb_q;
  logic                          ok_q, ok_now;

  logic [vcfe_pkg::CountW-1:0]   i_q;
  logic                          p1_q, p2_q;
  logic [vcfe_pkg::AddrW-1:0]    idx1_q;
  logic [vcfe_pkg::PopW-1:0]     pop_q;
  logic                          miss_q, ch_q;
  logic [vcfe_pkg::SumW-1:0]     sum_q;
  logic [vcfe_pkg::CountW-1:0]   chosen_q;
  logic                          cvalid_q;
  logic [vcfe_pkg::FitW-1:0]     prod_q;

  logic                          done_q;
  vcfe_pkg::result_t             res_q;

  vcfe_pkg::mem_req_t            mreq;
  logic [vcfe_pkg::RowW-1:0]     rdata;
  logic [vcfe_pkg::RowW-1:0]     row_m, row_u;
  logic [vcfe_pkg::RowW-1:0]     bit_a, bit_b;
  logic                          issue;

  vcfe_row_store u_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // active vertex count and handshake
  assign n_now  = (vcount_q > vcfe_pkg::MaxVertices) ? vcfe_pkg::MaxVertices : vcount_q;
  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;
  assign bit_a  = vcfe_pkg::RowW'(1) << a_q;
  assign bit_b  = vcfe_pkg::RowW'(1) << b_q;
  assign ok_now = rng_q && ((cmd_q == vcfe_pkg::CmdAdd) || rowa_q[b_q]);
  assign issue  = (state_q == StEvRead) && (i_q < n_q);

  // row of the count pipeline, restricted to vertices in use and outside the cover
  assign row_m = rdata & inuse_q & unch_q;
  assign row_u = row_m & ({vcfe_pkg::RowW{1'b1}} << idx1_q);

  // sequencer and row store requests
  always_comb begin
    state_d = state_q;
    mreq    = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.command == vcfe_pkg::CmdAdd || item_i.command == vcfe_pkg::CmdRemove) begin
            state_d = StRdA;
          end else if (item_i.command == vcfe_pkg::CmdEval) begin
            state_d = StEvRead;
          end
        end
      end
      StRdA: begin
        mreq.re    = 1'b1;
        mreq.raddr = a_q;
        state_d    = StRdB;
      end
      StRdB: begin
        mreq.re    = 1'b1;
        mreq.raddr = b_q;
        state_d    = StWrA;
      end
      StWrA: begin
        mreq.we    = ok_now;
        mreq.waddr = a_q;
        mreq.wdata = (cmd_q == vcfe_pkg::CmdAdd) ? (rowa_q | bit_b) : (rowa_q & ~bit_b);
        state_d    = StWrB;
      end
      StWrB: begin
        mreq.we    = ok_q;
        mreq.waddr = b_q;
        mreq.wdata = (cmd_q == vcfe_pkg::CmdAdd) ? (rowb_q | bit_a) : (rowb_q & ~bit_a);
        state_d    = StIdle;
      end
      StEvRead: begin
        if (issue) begin
          mreq.re    = 1'b1;
          mreq.raddr = i_q[vcfe_pkg::AddrW-1:0];
        end else begin
          state_d = StEvDrain;
        end
      end
      StEvDrain: begin
        if (!p1_q && !p2_q) begin
          state_d = StEvMul;
        end
      end
      StEvMul: begin
        state_d = StEvFin;
      end
      StEvFin: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      vcount_q <= vcfe_pkg::CountReset;
      done_q   <= 1'b0;
      p1_q     <= 1'b0;
      p2_q     <= 1'b0;
      i_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      done_q <= (accept && item_i.command == vcfe_pkg::CmdUnused) || (state_q == StWrB) ||
                (state_q == StEvFin);
      p1_q   <= issue;
      p2_q   <= p1_q;
      if (accept) begin
        i_q <= '0;
      end else if (issue) begin
        i_q <= i_q + vcfe_pkg::CountW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // latch the transaction
    if (accept) begin
      cmd_q    <= item_i.command;
      a_q      <= item_i.first_vertex;
      b_q      <= item_i.second_vertex;
      n_q      <= n_now;
      rng_q    <= (vcfe_pkg::CountW'(item_i.first_vertex) < n_now) &&
                  (vcfe_pkg::CountW'(item_i.second_vertex) < n_now);
      inuse_q  <= vcfe_pkg::low_bits(n_now);
      unch_q   <= ~item_i.member_mask & vcfe_pkg::low_bits(n_now);
      sum_q    <= '0;
      chosen_q <= '0;
      cvalid_q <= 1'b1;
    end
    // edge command row captures
    if (state_q == StRdB) begin
      rowa_q <= rdata;
    end
    if (state_q == StWrA) begin
      rowb_q <= rdata;
      ok_q   <= ok_now;
    end
    // count stage: uncovered neighbors at or above the row index
    idx1_q <= i_q[vcfe_pkg::AddrW-1:0];
    ch_q   <= !unch_q[idx1_q];
    pop_q  <= unch_q[idx1_q] ? vcfe_pkg::pop_row(row_u) : '0;
    miss_q <= unch_q[idx1_q] && (row_m != '0);
    // accumulate stage
    if (p2_q) begin
      sum_q    <= sum_q + vcfe_pkg::SumW'(pop_q);
      chosen_q <= chosen_q + vcfe_pkg::CountW'(ch_q);
      if (miss_q) begin
        cvalid_q <= 1'b0;
      end
    end
    // penalty scaling at full result width
    if (state_q == StEvMul) begin
      prod_q <= vcfe_pkg::FitW'(sum_q) * vcfe_pkg::FitW'(n_q);
    end
    // result register
    if (accept) begin
      res_q <= '0;
    end else if (state_q == StWrB) begin
      res_q.accepted    <= ok_q;
      res_q.fitness     <= '0;
      res_q.cover_valid <= 1'b0;
    end else if (state_q == StEvFin) begin
      res_q.accepted    <= 1'b0;
      res_q.fitness     <= prod_q + vcfe_pkg::FitW'(chosen_q);
      res_q.cover_valid <= cvalid_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // results are only issued once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> state_q == StIdle)
    else $error("result issued while sequencer busy");

  // the row store is written only in the two write steps of an edge command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.we |-> (state_q == StWrA || state_q == StWrB))
    else $error("row store written outside an edge command");

  // an accepted edge command never carries a fitness or cover flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.accepted) |-> (res_q.fitness == '0 && !res_q.cover_valid))
    else $error("edge result carries evaluate fields");

  // the count pipeline is empty whenever the product is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEvMul) |-> (!p1_q && !p2_q))
    else $error("multiply started before count pipeline drained");

  // a row read is never issued at or beyond the active count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq.re && state_q == StEvRead) |-> (vcfe_pkg::CountW'(mreq.raddr) < n_q))
    else $error("row read beyond active vertex count");

endmodule
